// ----- rtl/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg: shared definitions for the stack machine execute unit
// Sizes, opcode and error codes, microcode control word and the microcode ROM.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int STACK_DEPTH   = 8;
  localparam int LOCAL_SLOTS   = 8;
  localparam int PROGRAM_DEPTH = 4096;   // power of two, at most 1 << PC_BITS
  localparam int NAME_BITS     = 8;

  localparam int DATA_W  = 64;
  localparam int PC_BITS = 12;
  localparam int SC_W    = $clog2(STACK_DEPTH + 1);
  localparam int SI_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LC_W    = $clog2(LOCAL_SLOTS + 1);
  localparam int LI_W    = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
  localparam logic [PC_BITS-1:0] PC_MASK = PC_BITS'(PROGRAM_DEPTH - 1);

  typedef enum logic [3:0] {
    OP_HALT, OP_LABEL, OP_ALLOC, OP_LOAD, OP_STORE, OP_PUSH, OP_JMP,
    OP_JZ, OP_LT, OP_EQ, OP_AND, OP_ADD, OP_PRINTLN
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_OVERFLOW, ERR_UNDERFLOW, ERR_LOCALS_FULL, ERR_NO_NAME, ERR_BAD_OP
  } err_t;

  typedef enum logic [1:0] {STK_NONE, STK_POP, STK_BIN, STK_PUSH} stk_t;
  typedef enum logic [1:0] {SRC_IMM, SRC_LOCAL, SRC_ALU} src_t;
  typedef enum logic [1:0] {LOC_NONE, LOC_ALLOC, LOC_STORE} loc_t;
  typedef enum logic [1:0] {PC_INC, PC_TARGET, PC_JZ, PC_HOLD} pcs_t;
  typedef enum logic [1:0] {ALU_LT, ALU_EQ, ALU_AND, ALU_ADD} alu_t;

  // One microcode word.
  typedef struct packed {
    logic dispatch;  // read/check step: branch to stop, fault or opcode word
    logic finish;    // last step: commit state, emit the result
    logic fault;     // latch the pending error and stop
    logic halt;
    logic print;
    stk_t stk;
    src_t src;
    loc_t loc;
    pcs_t pcs;
    alu_t alu;
  } ctrl_t;

  localparam int UADDR_W = 4;
  typedef logic [UADDR_W-1:0] uaddr_t;

  localparam uaddr_t U_READ  = UADDR_W'(0);
  localparam uaddr_t U_STOP  = UADDR_W'(1);
  localparam uaddr_t U_FAULT = UADDR_W'(2);
  localparam uaddr_t U_EXEC  = UADDR_W'(3);  // plus opcode

  function automatic ctrl_t ucode(input uaddr_t a);
    ctrl_t c;
    c.dispatch = 1'b0;
    c.finish   = 1'b1;
    c.fault    = 1'b0;
    c.halt     = 1'b0;
    c.print    = 1'b0;
    c.stk      = STK_NONE;
    c.src      = SRC_IMM;
    c.loc      = LOC_NONE;
    c.pcs      = PC_INC;
    c.alu      = ALU_ADD;
    unique case (a)
      U_READ: begin
        c.dispatch = 1'b1;
        c.finish   = 1'b0;
      end
      U_STOP:  c.pcs = PC_HOLD;
      U_FAULT: begin
        c.fault = 1'b1;
        c.pcs   = PC_HOLD;
      end
      U_EXEC + UADDR_W'(OP_HALT): begin
        c.halt = 1'b1;
        c.pcs  = PC_HOLD;
      end
      U_EXEC + UADDR_W'(OP_LABEL): c.pcs = PC_INC;
      U_EXEC + UADDR_W'(OP_ALLOC): begin
        c.stk = STK_POP;
        c.loc = LOC_ALLOC;
      end
      U_EXEC + UADDR_W'(OP_LOAD): begin
        c.stk = STK_PUSH;
        c.src = SRC_LOCAL;
      end
      U_EXEC + UADDR_W'(OP_STORE): begin
        c.stk = STK_POP;
        c.loc = LOC_STORE;
      end
      U_EXEC + UADDR_W'(OP_PUSH): c.stk = STK_PUSH;
      U_EXEC + UADDR_W'(OP_JMP):  c.pcs = PC_TARGET;
      U_EXEC + UADDR_W'(OP_JZ): begin
        c.stk = STK_POP;
        c.pcs = PC_JZ;
      end
      U_EXEC + UADDR_W'(OP_LT): begin
        c.stk = STK_BIN;
        c.src = SRC_ALU;
        c.alu = ALU_LT;
      end
      U_EXEC + UADDR_W'(OP_EQ): begin
        c.stk = STK_BIN;
        c.src = SRC_ALU;
        c.alu = ALU_EQ;
      end
      U_EXEC + UADDR_W'(OP_AND): begin
        c.stk = STK_BIN;
        c.src = SRC_ALU;
        c.alu = ALU_AND;
      end
      U_EXEC + UADDR_W'(OP_ADD): begin
        c.stk = STK_BIN;
        c.src = SRC_ALU;
        c.alu = ALU_ADD;
      end
      U_EXEC + UADDR_W'(OP_PRINTLN): begin
        c.stk   = STK_POP;
        c.print = 1'b1;
      end
      default: begin
        c.dispatch = 1'b1;  // unused addresses fall back to the read step
        c.finish   = 1'b0;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/stack_vm_execute_unit.sv -----
// ----------------------------------------------------------------------------
// stack_vm_execute_unit: execute stage of a small stack machine
// Runs one decoded instruction per input transfer and reports the next PC.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one decoded instruction per transfer into a one-entry input
//   buffer. m_* returns one result per instruction, in order: next PC, the
//   println value (flagged by m_tuser), the halted flag and the sticky error.
//   Control is a 16-word microcode ROM with a micro-PC. Every instruction
//   runs two micro-steps: a read/check step (stack top pair and the matched
//   local are read from their memories into registers, the newest-first name
//   search and the error checks are done, and the micro-PC branches to the
//   stop word, the fault word or the opcode's word) and an execute step
//   (ALU, stack/local write, PC update, result register load).
//   The buffer takes the next transfer in the cycle the current instruction
//   finishes. The result is registered by the execute step.
//   The execute step waits while the output register holds an untaken
//   result; state is committed only when the result is loaded, so a stalled
//   receiver stalls the machine without losing anything.
//   Reset (rst, synchronous) empties both registers and clears stack depth,
//   local count, PC, stop flag and error. Stack and local memories are not
//   cleared; only values from entries already written are ever used.
// ----------------------------------------------------------------------------
module stack_vm_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] req_type, [67:4] immediate, [75:68] name_id, [87:76] jump_target
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] next_pc, [75:12] print_value, [76] halted, [79:77] error_code
  output logic [79:0] m_tdata,
  // [0] print_valid
  output logic        m_tuser
);
  import svm_pkg::*;

  // input buffer
  logic                ib_valid;
  op_t                 ib_op;
  logic [DATA_W-1:0]   ib_imm;
  logic [NAME_BITS-1:0] ib_name;
  logic [PC_BITS-1:0]  ib_target;

  // architectural state
  logic [DATA_W-1:0]    stack_mem   [STACK_DEPTH];
  logic [DATA_W-1:0]    local_values[LOCAL_SLOTS];
  logic [NAME_BITS-1:0] local_names [LOCAL_SLOTS];
  logic [SC_W-1:0]      stack_count;
  logic [LC_W-1:0]      local_count;
  logic [PC_BITS-1:0]   pc;
  logic                 stopped;
  err_t                 latched_error;

  // sequencer
  uaddr_t upc, upc_next;
  ctrl_t  ctrl;

  // registered operands from the read step
  logic [DATA_W-1:0] tos, nos, lval;
  logic [LI_W-1:0]   slot_r;
  err_t              err_r;

  logic              out_free, read_go, finish_go;
  logic              found;
  logic [LI_W-1:0]   slot;
  err_t              chk_err;
  logic [SC_W-1:0]   sp_m1, sp_m2, sc_next;
  logic [LC_W-1:0]   lc_next;
  logic [DATA_W-1:0] alu_res, push_data;
  logic [PC_BITS-1:0] pc_inc, pc_next;
  logic              stopped_next;
  err_t              err_next;

  assign ctrl      = ucode(upc);
  assign out_free  = !m_tvalid || m_tready;
  assign read_go   = ctrl.dispatch && ib_valid;
  assign finish_go = ctrl.finish && out_free;
  // buffer frees the cycle the current instruction finishes
  assign s_tready  = !ib_valid || finish_go;

  assign sp_m1 = stack_count - SC_W'(1);
  assign sp_m2 = stack_count - SC_W'(2);

  // newest-first search: a higher valid slot overrides a lower one
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = 0; i < LOCAL_SLOTS; i++) begin
      if (LC_W'(i) < local_count && local_names[i] == ib_name) begin
        found = 1'b1;
        slot  = LI_W'(i);
      end
    end
  end

  // error checks, in the order each opcode defines
  always_comb begin
    chk_err = ERR_NONE;
    unique case (ib_op)
      OP_HALT, OP_LABEL, OP_JMP: chk_err = ERR_NONE;
      OP_ALLOC: begin
        if (stack_count == '0)                      chk_err = ERR_UNDERFLOW;
        else if (local_count >= LC_W'(LOCAL_SLOTS)) chk_err = ERR_LOCALS_FULL;
      end
      OP_LOAD: begin
        if (!found)                                 chk_err = ERR_NO_NAME;
        else if (stack_count >= SC_W'(STACK_DEPTH)) chk_err = ERR_OVERFLOW;
      end
      OP_STORE: begin
        if (!found)                  chk_err = ERR_NO_NAME;
        else if (stack_count == '0)  chk_err = ERR_UNDERFLOW;
      end
      OP_PUSH: if (stack_count >= SC_W'(STACK_DEPTH)) chk_err = ERR_OVERFLOW;
      OP_JZ, OP_PRINTLN: if (stack_count == '0) chk_err = ERR_UNDERFLOW;
      OP_LT, OP_EQ, OP_AND, OP_ADD: if (stack_count < SC_W'(2)) chk_err = ERR_UNDERFLOW;
      default: chk_err = ERR_BAD_OP;
    endcase
  end

  // micro-PC: conditional branch out of the read step
  always_comb begin
    upc_next = upc;
    if (read_go) begin
      priority if (stopped)              upc_next = U_STOP;
      else if (chk_err != ERR_NONE)      upc_next = U_FAULT;
      else                               upc_next = U_EXEC + UADDR_W'(ib_op);
    end else if (finish_go) begin
      upc_next = U_READ;
    end
  end

  // execute datapath
  always_comb begin
    unique case (ctrl.alu)
      ALU_LT:  alu_res = DATA_W'($signed(nos) < $signed(tos));
      ALU_EQ:  alu_res = DATA_W'(nos == tos);
      ALU_AND: alu_res = nos & tos;
      ALU_ADD: alu_res = nos + tos;
      default: alu_res = nos + tos;
    endcase
    unique case (ctrl.src)
      SRC_IMM:   push_data = ib_imm;
      SRC_LOCAL: push_data = lval;
      SRC_ALU:   push_data = alu_res;
      default:   push_data = ib_imm;
    endcase
    unique case (ctrl.stk)
      STK_NONE: sc_next = stack_count;
      STK_POP:  sc_next = sp_m1;
      STK_BIN:  sc_next = sp_m1;
      STK_PUSH: sc_next = stack_count + SC_W'(1);
      default:  sc_next = stack_count;
    endcase
    lc_next = (ctrl.loc == LOC_ALLOC) ? local_count + LC_W'(1) : local_count;
    pc_inc  = (pc + PC_BITS'(1)) & PC_MASK;
    unique case (ctrl.pcs)
      PC_INC:    pc_next = pc_inc;
      PC_TARGET: pc_next = ib_target & PC_MASK;
      PC_JZ:     pc_next = (tos == '0) ? (ib_target & PC_MASK) : pc_inc;
      PC_HOLD:   pc_next = pc;
      default:   pc_next = pc;
    endcase
    stopped_next = stopped | ctrl.halt | ctrl.fault;
    err_next     = ctrl.fault ? err_r : latched_error;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      upc           <= U_READ;
      stack_count   <= '0;
      local_count   <= '0;
      pc            <= '0;
      stopped       <= 1'b0;
      latched_error <= ERR_NONE;
    end else begin
      upc <= upc_next;
      if (s_tvalid && s_tready) ib_valid <= 1'b1;
      else if (finish_go)       ib_valid <= 1'b0;
      if (finish_go)     m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (finish_go) begin
        stack_count   <= sc_next;
        local_count   <= lc_next;
        pc            <= pc_next;
        stopped       <= stopped_next;
        latched_error <= err_next;
      end
    end
  end

  // input buffer payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ib_op     <= op_t'(s_tdata[3:0]);
      ib_imm    <= s_tdata[67:4];
      ib_name   <= s_tdata[68 +: NAME_BITS];
      ib_target <= s_tdata[87:76];
    end
  end

  // read step: registered memory reads and check result
  always_ff @(posedge clk) begin
    if (read_go) begin
      tos    <= stack_mem[sp_m1[SI_W-1:0]];
      nos    <= stack_mem[sp_m2[SI_W-1:0]];
      lval   <= local_values[slot];
      slot_r <= slot;
      err_r  <= chk_err;
    end
  end

  // operand stack memory: one write port
  always_ff @(posedge clk) begin
    if (finish_go && ctrl.stk == STK_PUSH) stack_mem[stack_count[SI_W-1:0]] <= push_data;
    else if (finish_go && ctrl.stk == STK_BIN) stack_mem[sp_m2[SI_W-1:0]] <= push_data;
  end

  // locals: alloc appends at the fill point, store rewrites the matched slot
  always_ff @(posedge clk) begin
    if (finish_go && ctrl.loc == LOC_ALLOC) begin
      local_values[local_count[LI_W-1:0]] <= tos;
      local_names[local_count[LI_W-1:0]]  <= ib_name;
    end else if (finish_go && ctrl.loc == LOC_STORE) begin
      local_values[slot_r] <= tos;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      m_tdata[11:0]  <= pc_next;
      m_tdata[75:12] <= ctrl.print ? tos : '0;
      m_tdata[76]    <= stopped_next;
      m_tdata[79:77] <= err_next;
      m_tuser        <= ctrl.print;
    end
  end

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("stop flag cleared without reset");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= SC_W'(STACK_DEPTH)) else $error("stack depth out of range");
  a_local_bound: assert property (@(posedge clk) disable iff (rst)
    local_count <= LC_W'(LOCAL_SLOTS)) else $error("local count out of range");
  a_print_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[79:77] == ERR_NONE && !m_tdata[76]))
    else $error("print reported on a stopped machine");
`endif

endmodule
